/* hdl/lgrw_pkg.sv */
package lgrw_pkg;

    // field widths of the request and response beats
    localparam int REQ_W       = 2;
    localparam int TEAM_W      = 6;
    localparam int POINTS_W    = 8;
    localparam int RAND_W      = 16;
    localparam int VISIT_OUT_W = 17;
    localparam int CFG_W       = 7;
    localparam int LOSS_W      = 8;

    // defaults for the top-level parameters
    localparam int MAX_TEAMS_DEF   = 64;
    localparam int RAND_BITS_DEF   = 16;
    localparam int VISIT_WIDTH_DEF = 17;

    localparam logic [CFG_W-1:0]  NUM_TEAMS_RST = 7'd64;
    localparam logic [LOSS_W-1:0] LOSS_MAX      = 8'hFF;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_GAME  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

    // response status
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [TEAM_W-1:0]   team_a;
        logic [POINTS_W-1:0] points_a;
        logic [TEAM_W-1:0]   team_b;
        logic [POINTS_W-1:0] points_b;
        logic [RAND_W-1:0]   rand_value;
    } t_req;

    typedef struct packed {
        logic                   status;
        logic [TEAM_W-1:0]      current_team;
        logic [VISIT_OUT_W-1:0] visit_count;
    } t_resp;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_GAME_WR,
        ST_VISIT,
        ST_SUM,
        ST_MUL,
        ST_PICK,
        ST_SEL,
        ST_DONE
    } t_state;

endpackage

/* hdl/lgrw_ram.sv */
module lgrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lgrw_scale.sv */
module lgrw_scale #(
    parameter int RAND_BITS = 16,
    parameter int COUNT_W   = 15
) (
    input  logic                 i_clk,
    input  logic [RAND_BITS-1:0] i_rand,
    input  logic [COUNT_W-1:0]   i_count,
    output logic [COUNT_W-1:0]   o_pick
);

    localparam int PW = RAND_BITS + COUNT_W;

    logic [PW-1:0] r_prod;

    // floor(rand * count / 2^RAND_BITS), product registered
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_rand) * PW'(i_count);
    end

    assign o_pick = COUNT_W'(r_prod >> RAND_BITS);

endmodule

/* hdl/lgrw_out_reg.sv */
module lgrw_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  lgrw_pkg::t_resp      i_data,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output lgrw_pkg::t_resp      o_data
);

    logic            r_valid;
    lgrw_pkg::t_resp r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

/* hdl/loss_graph_random_walk.sv */
// record game reads a loss entry and writes it back plus one; start walk picks
//   a team; walk step makes a summing sweep and a select sweep over one loss row, one entry a cycle
// one request at a time; the loss memory read port sets the walk step time
// the response register frees the input for the next request
// reset: synchronous active low; afterwards a clearing pass writes zero to every
//   loss entry (MAX_TEAMS*MAX_TEAMS, 4096 by default) before the first beat
module loss_graph_random_walk #(
    parameter int MAX_TEAMS   = lgrw_pkg::MAX_TEAMS_DEF,
    parameter int RAND_BITS   = lgrw_pkg::RAND_BITS_DEF,
    parameter int VISIT_WIDTH = lgrw_pkg::VISIT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lgrw_pkg::t_req              i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lgrw_pkg::t_resp             o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lgrw_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int TW    = $clog2(MAX_TEAMS);
    localparam int DEPTH = MAX_TEAMS * MAX_TEAMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_TEAMS + 1);
    localparam int SW    = $clog2(MAX_TEAMS * 255 + 1);
    localparam int NW    = lgrw_pkg::CFG_W;
    localparam int N_CAP = (MAX_TEAMS < 127) ? MAX_TEAMS : 127;
    localparam logic [VISIT_WIDTH-1:0] VISIT_MAX = '1;

    lgrw_pkg::t_state r_state, n_state;
    lgrw_pkg::t_req   r_req, n_req;
    logic [RAND_BITS-1:0] r_rand, n_rand;
    logic                 r_status, n_status;
    logic [VISIT_WIDTH-1:0] r_vcount, n_vcount;
    logic [TW-1:0]        r_pos, n_pos;
    logic [NW-1:0]        r_num_teams;
    logic [MAX_TEAMS-1:0] r_vvalid, n_vvalid;
    logic [AW-1:0]        r_clr, n_clr;
    logic [AW-1:0]        r_game_addr, n_game_addr;
    logic [CW-1:0]        r_col, n_col;
    logic                 r_rd_vld, n_rd_vld;
    logic [CW-1:0]        r_rd_col, n_rd_col;
    logic [SW-1:0]        r_sum, n_sum;
    logic [SW-1:0]        r_run, n_run;
    logic [SW-1:0]        r_t, n_t;

    logic [NW-1:0]   eff_teams;
    logic            in_fire;
    logic            ta_ok, tb_ok, pos_ok;
    logic [TW-1:0]   ta_idx, tb_idx, loser, winner;
    logic [AW-1:0]   game_addr, row_base;
    logic            issue, sweep_done, sel_hit;
    logic [SW-1:0]   run_new;
    logic [TW-1:0]   vis_addr;
    logic [VISIT_WIDTH-1:0] vis_cur;

    logic              loss_we, loss_re;
    logic [AW-1:0]     loss_waddr, loss_raddr;
    logic [lgrw_pkg::LOSS_W-1:0] loss_wdata, loss_rdata;
    logic              vis_we, vis_re;
    logic [TW-1:0]     vis_waddr;
    logic [VISIT_WIDTH-1:0] vis_wdata, vis_rdata;
    logic [SW-1:0]     mul_count, pick;
    logic              out_free, out_load;
    lgrw_pkg::t_resp   resp;

    // zero reads as one, anything above the memory size (capped at 127) as that cap
    always_comb begin
        if (r_num_teams == '0) begin
            eff_teams = NW'(1);
        end else if (int'(r_num_teams) > N_CAP) begin
            eff_teams = NW'(N_CAP);
        end else begin
            eff_teams = r_num_teams;
        end
    end

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == lgrw_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign ta_ok  = int'(r_req.team_a) < int'(eff_teams);
    assign tb_ok  = int'(r_req.team_b) < int'(eff_teams);
    assign pos_ok = int'(r_pos) < int'(eff_teams);
    assign ta_idx = TW'(r_req.team_a);
    assign tb_idx = TW'(r_req.team_b);

    // a tie goes to team b
    assign loser     = (r_req.points_a > r_req.points_b) ? tb_idx : ta_idx;
    assign winner    = (r_req.points_a > r_req.points_b) ? ta_idx : tb_idx;
    assign game_addr = AW'(loser) * AW'(MAX_TEAMS) + AW'(winner);
    assign row_base  = AW'(r_pos) * AW'(MAX_TEAMS);

    // row sweep: a read is issued and its data comes back in the following cycle
    assign issue      = int'(r_col) < int'(eff_teams);
    assign sweep_done = !issue && !r_rd_vld;
    assign run_new    = r_run + SW'(loss_rdata);
    assign sel_hit    = r_rd_vld && (run_new > r_t);

    assign vis_addr = (r_req.req_type == lgrw_pkg::REQ_STEP) ? r_pos : ta_idx;
    assign vis_cur  = r_vvalid[vis_addr] ? vis_rdata : '0;

    assign mul_count = (r_req.req_type == lgrw_pkg::REQ_STEP && r_sum != '0)
                       ? r_sum : SW'(eff_teams);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgrw_pkg::ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = lgrw_pkg::ST_IDLE;
            end
            lgrw_pkg::ST_IDLE: begin
                if (in_fire) n_state = lgrw_pkg::ST_DECODE;
            end
            lgrw_pkg::ST_DECODE: begin
                case (r_req.req_type)
                    lgrw_pkg::REQ_GAME:
                        n_state = (ta_ok && tb_ok) ? lgrw_pkg::ST_GAME_WR : lgrw_pkg::ST_DONE;
                    lgrw_pkg::REQ_START:
                        n_state = lgrw_pkg::ST_MUL;
                    lgrw_pkg::REQ_STEP:
                        n_state = pos_ok ? lgrw_pkg::ST_VISIT : lgrw_pkg::ST_DONE;
                    lgrw_pkg::REQ_READ:
                        n_state = ta_ok ? lgrw_pkg::ST_VISIT : lgrw_pkg::ST_DONE;
                    default:
                        n_state = lgrw_pkg::ST_DONE;
                endcase
            end
            lgrw_pkg::ST_GAME_WR: n_state = lgrw_pkg::ST_DONE;
            lgrw_pkg::ST_VISIT: begin
                n_state = (r_req.req_type == lgrw_pkg::REQ_READ)
                          ? lgrw_pkg::ST_DONE : lgrw_pkg::ST_SUM;
            end
            lgrw_pkg::ST_SUM: begin
                if (sweep_done) n_state = lgrw_pkg::ST_MUL;
            end
            lgrw_pkg::ST_MUL: n_state = lgrw_pkg::ST_PICK;
            lgrw_pkg::ST_PICK: begin
                n_state = (r_req.req_type == lgrw_pkg::REQ_START || r_sum == '0)
                          ? lgrw_pkg::ST_DONE : lgrw_pkg::ST_SEL;
            end
            lgrw_pkg::ST_SEL: begin
                if (sel_hit || sweep_done) n_state = lgrw_pkg::ST_DONE;
            end
            lgrw_pkg::ST_DONE: begin
                if (out_free) n_state = lgrw_pkg::ST_IDLE;
            end
            default: n_state = lgrw_pkg::ST_IDLE;
        endcase
    end

    // memory controls and response load
    always_comb begin
        loss_we    = 1'b0;
        loss_waddr = r_clr;
        loss_wdata = '0;
        loss_re    = 1'b0;
        loss_raddr = row_base + AW'(r_col);
        vis_re     = 1'b0;
        vis_we     = 1'b0;
        vis_waddr  = r_pos;
        vis_wdata  = (vis_cur == VISIT_MAX) ? VISIT_MAX : vis_cur + 1'b1;
        out_load   = 1'b0;
        case (r_state)
            lgrw_pkg::ST_CLEAR: begin
                loss_we = 1'b1;
            end
            lgrw_pkg::ST_DECODE: begin
                if (r_req.req_type == lgrw_pkg::REQ_GAME && ta_ok && tb_ok) begin
                    loss_re    = 1'b1;
                    loss_raddr = game_addr;
                end
                vis_re = (r_req.req_type == lgrw_pkg::REQ_STEP && pos_ok)
                      || (r_req.req_type == lgrw_pkg::REQ_READ && ta_ok);
            end
            lgrw_pkg::ST_GAME_WR: begin
                loss_we    = 1'b1;
                loss_waddr = r_game_addr;
                loss_wdata = (loss_rdata == lgrw_pkg::LOSS_MAX)
                             ? lgrw_pkg::LOSS_MAX : loss_rdata + 1'b1;
            end
            lgrw_pkg::ST_VISIT: begin
                vis_we = (r_req.req_type == lgrw_pkg::REQ_STEP);
            end
            lgrw_pkg::ST_SUM, lgrw_pkg::ST_SEL: begin
                loss_re = issue;
            end
            lgrw_pkg::ST_DONE: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_req       = r_req;
        n_rand      = r_rand;
        n_status    = r_status;
        n_vcount    = r_vcount;
        n_pos       = r_pos;
        n_vvalid    = r_vvalid;
        n_clr       = r_clr;
        n_game_addr = r_game_addr;
        n_col       = r_col;
        n_rd_vld    = r_rd_vld;
        n_rd_col    = r_rd_col;
        n_sum       = r_sum;
        n_run       = r_run;
        n_t         = r_t;
        case (r_state)
            lgrw_pkg::ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
            end
            lgrw_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_req    = i_in_data;
                    n_rand   = RAND_BITS'(i_in_data.rand_value);
                    n_status = lgrw_pkg::STATUS_OK;
                    n_vcount = '0;
                end
            end
            lgrw_pkg::ST_DECODE: begin
                case (r_req.req_type)
                    lgrw_pkg::REQ_GAME: begin
                        if (!(ta_ok && tb_ok)) n_status = lgrw_pkg::STATUS_RANGE;
                        n_game_addr = game_addr;
                    end
                    lgrw_pkg::REQ_START: begin
                        n_vvalid = '0;
                    end
                    lgrw_pkg::REQ_STEP: begin
                        if (!pos_ok) n_status = lgrw_pkg::STATUS_RANGE;
                    end
                    lgrw_pkg::REQ_READ: begin
                        if (!ta_ok) n_status = lgrw_pkg::STATUS_RANGE;
                    end
                    default: ;
                endcase
            end
            lgrw_pkg::ST_VISIT: begin
                if (r_req.req_type == lgrw_pkg::REQ_READ) begin
                    n_vcount = vis_cur;
                end else begin
                    n_vvalid[r_pos] = 1'b1;
                    n_col    = '0;
                    n_rd_vld = 1'b0;
                    n_sum    = '0;
                end
            end
            lgrw_pkg::ST_SUM: begin
                n_rd_vld = issue;
                n_rd_col = r_col;
                if (issue) n_col = r_col + 1'b1;
                if (r_rd_vld) n_sum = r_sum + SW'(loss_rdata);
            end
            lgrw_pkg::ST_PICK: begin
                if (r_req.req_type == lgrw_pkg::REQ_START || r_sum == '0) begin
                    n_pos = TW'(pick);
                end else begin
                    n_t      = pick;
                    n_col    = '0;
                    n_run    = '0;
                    n_rd_vld = 1'b0;
                end
            end
            lgrw_pkg::ST_SEL: begin
                n_rd_vld = issue;
                n_rd_col = r_col;
                if (issue) n_col = r_col + 1'b1;
                if (r_rd_vld) n_run = run_new;
                // first column whose running sum passes the target, else the last team
                if (sel_hit) begin
                    n_pos = TW'(r_rd_col);
                end else if (sweep_done) begin
                    n_pos = TW'(eff_teams - 1'b1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lgrw_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_pos       <= '0;
            r_vvalid    <= '0;
            r_rd_vld    <= 1'b0;
            r_num_teams <= lgrw_pkg::NUM_TEAMS_RST;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pos    <= n_pos;
            r_vvalid <= n_vvalid;
            r_rd_vld <= n_rd_vld;
            if (i_cfg_valid) begin
                r_num_teams <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_rand      <= n_rand;
        r_status    <= n_status;
        r_vcount    <= n_vcount;
        r_game_addr <= n_game_addr;
        r_col       <= n_col;
        r_rd_col    <= n_rd_col;
        r_sum       <= n_sum;
        r_run       <= n_run;
        r_t         <= n_t;
    end

    lgrw_ram #(
        .WIDTH (lgrw_pkg::LOSS_W),
        .DEPTH (DEPTH)
    ) u_loss_ram (
        .i_clk   (i_clk),
        .i_we    (loss_we),
        .i_waddr (loss_waddr),
        .i_wdata (loss_wdata),
        .i_re    (loss_re),
        .i_raddr (loss_raddr),
        .o_rdata (loss_rdata)
    );

    lgrw_ram #(
        .WIDTH (VISIT_WIDTH),
        .DEPTH (MAX_TEAMS)
    ) u_visit_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_re    (vis_re),
        .i_raddr (vis_addr),
        .o_rdata (vis_rdata)
    );

    lgrw_scale #(
        .RAND_BITS (RAND_BITS),
        .COUNT_W   (SW)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rand  (r_rand),
        .i_count (mul_count),
        .o_pick  (pick)
    );

    always_comb begin
        resp.status       = r_status;
        resp.current_team = lgrw_pkg::TEAM_W'(r_pos);
        resp.visit_count  = lgrw_pkg::VISIT_OUT_W'(r_vcount);
    end

    lgrw_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_data  (resp),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == lgrw_pkg::ST_DECODE)
        else $error("accepted beat not decoded");

    a_loss_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        loss_we |-> !loss_re)
        else $error("loss memory read and write overlap");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lgrw_pkg::ST_SEL |-> r_run <= r_sum)
        else $error("running sum passed row sum");

    a_sum_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgrw_pkg::ST_SUM && r_rd_vld) |-> int'(r_rd_col) < int'(eff_teams))
        else $error("row sweep read past team count");

    a_vcount_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_vcount == '0 || r_req.req_type == lgrw_pkg::REQ_READ))
        else $error("visit count on non-read response");

endmodule
